// ----- hw/rtl/nsel_pkg.sv -----
// Shared types and constants for the eight-lane Newton square root block.
package nsel_pkg;

  localparam int unsigned LANE_SLOTS     = 8;
  localparam int unsigned DEF_LANES      = 8;
  localparam int unsigned DEF_MAX_ITER   = 32;
  localparam int unsigned CFG_W          = 31;
  localparam int unsigned VAL_W          = 32;
  localparam logic [CFG_W-1:0] GUESS_RST  = 31'd16777216;
  localparam logic [CFG_W-1:0] THRESH_RST = 31'd10737;

  typedef enum logic [0:0] {
    REG_INITIAL_GUESS = 1'b0,
    REG_THRESHOLD     = 1'b1
  } cfg_idx_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SQ,
    OP_ERR,
    OP_CU,
    OP_XC,
    OP_UPD,
    OP_ROOT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic all_conv;
  } dp_sts_t;

endpackage

// ----- hw/rtl/nsel_ctrl.sv -----
// Controller sequencing the Newton iteration micro-steps.
module nsel_ctrl import nsel_pkg::*; #(
  parameter int unsigned MAX_ITER = DEF_MAX_ITER
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    nc_set
);

  localparam int unsigned IW = $clog2(MAX_ITER + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ERR, S_CU, S_XC, S_UPD, S_ROOT, S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic          ov_r, ov_nxt;

  // Output register frees once taken; a new request may enter the same cycle.
  logic accept;
  assign accept   = (state_r == S_IDLE) && in_valid && (!ov_r || !out_stall);
  assign in_stall = !(state_r == S_IDLE && (!ov_r || !out_stall));
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    ov_nxt    = ov_r && out_stall;
    cmd.op    = OP_IDLE;
    nc_set    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op    = OP_LOAD;
          iter_nxt  = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.op = OP_ERR;
        state_nxt = S_CU;
      end
      S_CU: begin
        // Convergence flags from the error step are now valid.
        if (sts.all_conv || iter_r == IW'(MAX_ITER)) begin
          nc_set    = !sts.all_conv;
          state_nxt = S_ROOT;
        end else begin
          cmd.op    = OP_CU;
          state_nxt = S_XC;
        end
      end
      S_XC: begin
        cmd.op = OP_XC;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.op    = OP_UPD;
        iter_nxt  = iter_r + 1'b1;
        state_nxt = S_SQ;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_iter_cap: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= IW'(MAX_ITER)) else $error("iteration count beyond cap");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !state_nxt[0] && state_nxt == S_IDLE) |=> out_valid)
    else $error("result not presented");

endmodule

// ----- hw/rtl/nsel_dp.sv -----
// Per-lane datapath: registered multiply steps of the Newton update.
module nsel_dp import nsel_pkg::*; #(
  parameter int unsigned LANES = DEF_LANES
) (
  input  logic                             clk,
  input  dp_cmd_t                          cmd,
  input  logic [LANE_SLOTS-1:0][VAL_W-1:0] val_in,
  input  logic [CFG_W-1:0]                 guess_cfg,
  input  logic [CFG_W-1:0]                 thresh_cfg,
  output dp_sts_t                          sts,
  output logic [LANE_SLOTS-1:0][VAL_W-1:0] root
);

  logic [LANE_SLOTS-1:0][VAL_W-1:0]   x_r;
  logic signed [31:0]                 g_r [LANE_SLOTS];
  logic [LANE_SLOTS-1:0][31:0]        sq_r;
  logic [LANE_SLOTS-1:0][31:0]        cu_r;
  logic [LANE_SLOTS-1:0][33:0]        xc_r;
  logic [LANE_SLOTS-1:0]              conv_r;
  logic [LANE_SLOTS-1:0][VAL_W-1:0]   root_r;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v[63:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANE_SLOTS; i++) begin
      logic [31:0] m;
      logic [63:0] p;
      logic signed [35:0] t;
      logic signed [35:0] h;
      logic signed [41:0] e;
      logic [41:0] ae;
      m = g_r[i][31] ? 32'(-g_r[i]) : g_r[i];
      unique case (cmd.op)
        OP_LOAD: begin
          x_r[i] <= val_in[i];
          g_r[i] <= {1'b0, guess_cfg};
        end
        OP_SQ: begin
          p = m * m;
          sq_r[i] <= sat32({24'd0, p[63:24]});
        end
        OP_ERR: begin
          p = x_r[i] * sq_r[i];
          e = $signed({2'b0, p[63:24]}) - 42'sd1073741824;
          ae = e[41] ? 42'(-e) : 42'(e);
          conv_r[i] <= (i >= LANES) || (ae <= {11'd0, thresh_cfg});
        end
        OP_CU: begin
          p = sq_r[i] * m;
          cu_r[i] <= sat32({24'd0, p[63:24]});
        end
        OP_XC: begin
          p = x_r[i] * cu_r[i];
          xc_r[i] <= p[63:30];
        end
        OP_UPD: begin
          t = 36'(g_r[i]) + 36'(g_r[i]) + 36'(g_r[i])
              - (g_r[i][31] ? -$signed({2'b0, xc_r[i]}) : $signed({2'b0, xc_r[i]}));
          h = t >>> 1;
          if (h > 36'sh07FFF_FFFF) g_r[i] <= 32'sh7FFF_FFFF;
          else if (h < -36'sh080000000) g_r[i] <= 32'sh8000_0000;
          else g_r[i] <= h[31:0];
        end
        OP_ROOT: begin
          p = x_r[i] * g_r[i][31:0];
          root_r[i] <= (i >= LANES || g_r[i] <= 0) ? '0 : sat32({24'd0, p[63:24]});
        end
        default: ;
      endcase
    end
  end

  assign sts.all_conv = &conv_r;
  assign root = root_r;

endmodule

// ----- hw/rtl/newton_sqrt_eight_lane.sv -----
// Top level of the eight-lane Newton square root block.
// Each request of eight Q2.30 operands runs a shared inverse-root Newton loop:
// a convergence check runs the square and error steps, and each update adds
// the cube, cross and update steps before the next check, for at most MAX_ITER
// updates; a new request is taken only once the previous one has left the loop.
// Each update runs four dependent per-lane multiply steps. The result
// register frees the input side as soon as the previous result is taken.
module newton_sqrt_eight_lane import nsel_pkg::*; #(
  parameter int unsigned LANES    = DEF_LANES,
  parameter int unsigned MAX_ITER = DEF_MAX_ITER
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [VAL_W-1:0]  in_value_0, in_value_1, in_value_2, in_value_3,
  input  logic [VAL_W-1:0]  in_value_4, in_value_5, in_value_6, in_value_7,
  input  logic              in_last_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  out_root_0, out_root_1, out_root_2, out_root_3,
  output logic [VAL_W-1:0]  out_root_4, out_root_5, out_root_6, out_root_7,
  output logic              out_not_converged,
  output logic              out_last_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] guess_r, thresh_r;
  logic             last_r, nc_r, nc_set;
  logic             outbusy_r;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [LANE_SLOTS-1:0][VAL_W-1:0] vals, roots;
  logic [LANE_SLOTS-1:0][VAL_W-1:0] oroot_r;

  assign cfg_ready = 1'b1;
  assign vals = {in_value_7, in_value_6, in_value_5, in_value_4,
                 in_value_3, in_value_2, in_value_1, in_value_0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guess_r  <= GUESS_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_INITIAL_GUESS: guess_r  <= cfg_data;
        REG_THRESHOLD:     thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  nsel_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd, .nc_set
  );

  nsel_dp #(.LANES(LANES)) u_dp (
    .clk, .cmd, .val_in(vals), .guess_cfg(guess_r), .thresh_cfg(thresh_r),
    .sts, .root(roots)
  );

  // Hold the finished result in its own register while the next request runs.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) last_r <= in_last_in;
    if (cmd.op == OP_LOAD) nc_r <= 1'b0;
    else if (nc_set) nc_r <= 1'b1;
    if (cmd.op == OP_ROOT) outbusy_r <= 1'b1;
    else outbusy_r <= 1'b0;
    if (outbusy_r) begin
      oroot_r           <= roots;
      out_not_converged <= nc_r;
      out_last_out      <= last_r;
    end
  end

  assign out_root_0 = oroot_r[0];
  assign out_root_1 = oroot_r[1];
  assign out_root_2 = oroot_r[2];
  assign out_root_3 = oroot_r[3];
  assign out_root_4 = oroot_r[4];
  assign out_root_5 = oroot_r[5];
  assign out_root_6 = oroot_r[6];
  assign out_root_7 = oroot_r[7];

endmodule

// ----- test/tb.sv -----
// Testbench for the eight-lane Newton square root block: directed table, then random requests.
`timescale 1ns / 100ps
module tb import nsel_pkg::*;;

  localparam int LANES_N = 8;
  localparam int ITER_CAP = 32;

  typedef struct {
    logic [31:0] val [8];
    logic        last;
  } sqrt_req_t;

  typedef struct {
    logic [31:0] root [8];
    logic        nc;
    logic        last;
  } sqrt_res_t;

  typedef struct {
    logic [31:0] val [8];
    logic        last;
    bit          known;
    logic [31:0] root0;
    logic        nc;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_v [8] = '{default: '0};
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_r [8];
  logic out_not_converged, out_last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [30:0] guess_cfg, thresh_cfg;
  sqrt_res_t   expected_roots [$];
  int          fail_cnt = 0;
  bit          quiet_out = 1'b0;

  always #6 clk = ~clk;

  newton_sqrt_eight_lane uut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_value_0(in_v[0]), .in_value_1(in_v[1]), .in_value_2(in_v[2]), .in_value_3(in_v[3]),
    .in_value_4(in_v[4]), .in_value_5(in_v[5]), .in_value_6(in_v[6]), .in_value_7(in_v[7]),
    .in_last_in, .out_valid, .out_stall,
    .out_root_0(out_r[0]), .out_root_1(out_r[1]), .out_root_2(out_r[2]),
    .out_root_3(out_r[3]), .out_root_4(out_r[4]), .out_root_5(out_r[5]),
    .out_root_6(out_r[6]), .out_root_7(out_r[7]),
    .out_not_converged, .out_last_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  function automatic logic [63:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic logic [63:0] mag64(longint g);
    return (g < 0) ? 64'(-g) : 64'(g);
  endfunction

  function automatic logic [63:0] guess_sq(longint g);
    logic [63:0] m;
    m = mag64(g);
    return sat32((m * m) >> 24);
  endfunction

  function automatic bit lane_settled(logic [63:0] x, longint g);
    longint e;
    e = longint'((x * guess_sq(g)) >> 24) - (longint'(1) << 30);
    return mag64(e) <= {33'd0, thresh_cfg};
  endfunction

  function automatic longint newton_step(logic [63:0] x, longint g);
    logic [63:0] cu;
    longint xc, t, h;
    cu = sat32((guess_sq(g) * mag64(g)) >> 24);
    xc = longint'((x * cu) >> 30);
    if (g < 0) xc = -xc;
    t = 3 * g - xc;
    if (t >= 0) h = longint'(64'(t) >> 1);
    else h = -longint'((64'(-t) + 64'd1) >> 1);
    if (h > 64'sh7FFF_FFFF) h = 64'sh7FFF_FFFF;
    if (h < -64'sh8000_0000) h = -64'sh8000_0000;
    return h;
  endfunction

  function automatic sqrt_res_t predict_roots(sqrt_req_t rq);
    sqrt_res_t rs;
    longint g [8];
    int iter;
    bit done;
    iter = 0;
    for (int i = 0; i < 8; i++) g[i] = longint'(guess_cfg);
    forever begin
      done = 1'b1;
      for (int i = 0; i < LANES_N; i++)
        if (!lane_settled(64'(rq.val[i]), g[i])) done = 1'b0;
      if (done || iter >= ITER_CAP) break;
      for (int i = 0; i < LANES_N; i++) g[i] = newton_step(64'(rq.val[i]), g[i]);
      iter++;
    end
    for (int i = 0; i < 8; i++)
      rs.root[i] = (g[i] > 0) ? 32'(sat32((64'(rq.val[i]) * 64'(g[i])) >> 24)) : 32'd0;
    rs.nc = !done;
    rs.last = rq.last;
    return rs;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [30:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_INITIAL_GUESS) guess_cfg = data;
    else thresh_cfg = data;
  endtask

  task automatic drain_and_settle();
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (220) @(posedge clk);
  endtask

  // send one request; optional idle burst before it
  task automatic send_req(sqrt_req_t rq, bit idle_ok);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 8; i++) in_v[i] <= rq.val[i];
    in_last_in <= rq.last;
    do @(posedge clk); while (in_stall);
    expected_roots.push_back(predict_roots(rq));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h4000_0000 + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      2: return $urandom_range(32'h0800_0000, 32'hBFFF_FFFF);
      3: return $urandom_range(0, 255) << $urandom_range(0, 24);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 65535);
      default: return $urandom_range(32'h2000_0000, 32'h7FFF_FFFF);
    endcase
  endfunction

  // result side: random stall bursts, compare against oldest prediction
  initial begin
    sqrt_res_t ex;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected result root_0=%h", $time, out_r[0]);
          fail_cnt++;
        end else begin
          ex = expected_roots.pop_front();
          for (int i = 0; i < 8; i++)
            if (out_r[i] !== ex.root[i]) begin
              $display("%0t: root_%0d expected %h actual %h", $time, i, ex.root[i], out_r[i]);
              fail_cnt++;
            end
          if (out_not_converged !== ex.nc) begin
            $display("%0t: not_converged expected %b actual %b", $time, ex.nc,
                     out_not_converged);
            fail_cnt++;
          end
          if (out_last_out !== ex.last) begin
            $display("%0t: last_out expected %b actual %b", $time, ex.last, out_last_out);
            fail_cnt++;
          end
        end
      end
      if (!quiet_out && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8) - 1) @(posedge clk);
        // results held during the burst are not accepted
        @(posedge clk);
        out_stall <= 1'b0;
        #1;
        if (out_valid) begin
          // nothing: sampling happens on next edge
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [$];
    dir_row_t row;
    sqrt_req_t rq;
    sqrt_res_t pr;
    guess_cfg  = GUESS_RST;
    thresh_cfg = THRESH_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: operand 1.0 converges at once from reset guess 1.0
    row.known = 1'b1; row.last = 1'b0; row.root0 = 32'h4000_0000; row.nc = 1'b0;
    for (int i = 0; i < 8; i++) row.val[i] = 32'h4000_0000;
    dir_rows.push_back(row);
    // zero operand runs to the cap, root 0
    row.root0 = 32'd0; row.nc = 1'b1; row.last = 1'b1;
    for (int i = 0; i < 8; i++) row.val[i] = 32'h4000_0000;
    row.val[0] = 32'd0;
    dir_rows.push_back(row);
    row.known = 1'b0;
    for (int k = 0; k < 10; k++) begin
      row.last = k[0];
      for (int i = 0; i < 8; i++)
        case (k)
          0: row.val[i] = 32'hFFFF_FFFF;
          1: row.val[i] = 32'd1;
          2: row.val[i] = 32'h1000_0000;
          3: row.val[i] = 32'h8000_0000;
          4: row.val[i] = i[0] ? 32'hFFFF_FFFF : 32'd0;
          5: row.val[i] = 32'h4000_0000 << (i % 2);
          6: row.val[i] = 32'hAAAA_AAAA;
          7: row.val[i] = 32'h5555_5555;
          8: row.val[i] = 32'h3000_0000 + i * 32'h0100_0000;
          default: row.val[i] = 32'h0000_0100 << (i * 3);
        endcase
      dir_rows.push_back(row);
    end

    foreach (dir_rows[n]) begin
      rq.val = dir_rows[n].val;
      rq.last = dir_rows[n].last;
      if (dir_rows[n].known) begin
        pr = predict_roots(rq);
        if (pr.root[0] !== dir_rows[n].root0 || pr.nc !== dir_rows[n].nc) begin
          $display("%0t: table row %0d expected %h/%b predicted %h/%b", $time, n,
                   dir_rows[n].root0, dir_rows[n].nc, pr.root[0], pr.nc);
          fail_cnt++;
        end
      end
      send_req(rq, 1'b1);
    end
    idle_input();
    drain_and_settle();

    // settings, extremes included; guess 0 and huge guesses diverge or stick
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(REG_INITIAL_GUESS, 31'd0); write_reg(REG_THRESHOLD, 31'd0); end
        1: begin write_reg(REG_INITIAL_GUESS, 31'h7FFF_FFFF);
                 write_reg(REG_THRESHOLD, 31'h4000_0000); end
        2: begin write_reg(REG_INITIAL_GUESS, 31'd16777216);
                 write_reg(REG_THRESHOLD, 31'd1 << 20); end
        3: begin write_reg(REG_INITIAL_GUESS, 31'd12000000);
                 write_reg(REG_THRESHOLD, 31'd10737); end
        4: begin write_reg(REG_INITIAL_GUESS, 31'($urandom_range(0, 31'h7FFF_FFFF)));
                 write_reg(REG_THRESHOLD, 31'($urandom_range(0, 31'h7FFF_FFFF))); end
        5: begin write_reg(REG_INITIAL_GUESS, 31'h5555_5555);
                 write_reg(REG_THRESHOLD, 31'h2AAA_AAAA); end
        default: begin write_reg(REG_INITIAL_GUESS, 31'd16777216);
                       write_reg(REG_THRESHOLD, 31'd10737); end
      endcase
      for (int k = 0; k < (ph == 6 ? 240 : 85); k++) begin
        if (ph == 6 && k > 180) quiet_out = 1'b1;
        for (int i = 0; i < 8; i++) rq.val[i] = rand_operand();
        rq.last = $urandom_range(0, 1);
        send_req(rq, !(ph == 6 && k > 180));
      end
      idle_input();
      drain_and_settle();
    end

    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/nsel_pkg.sv
hw/rtl/nsel_ctrl.sv
hw/rtl/nsel_dp.sv
hw/rtl/newton_sqrt_eight_lane.sv
test/tb.sv
